// ----- rtl/dtrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dtrs_pkg;

  // Fixed field widths of the query and result transactions.
  localparam int FIELD_W = 16;
  localparam int VAL_W   = FIELD_W + 1;
  localparam int COUNT_W = 20;
  localparam int SIGMA_W = 33;

  // One query transaction.
  typedef struct packed {
    logic [FIELD_W-1:0] range_first;
    logic [FIELD_W-1:0] range_last;
    logic [FIELD_W-1:0] step_divisor;
  } dtrs_in_t;

  // One result transaction.
  typedef struct packed {
    logic [COUNT_W-1:0] count_total;
    logic [SIGMA_W-1:0] sigma_total;
  } dtrs_out_t;

  // A classified query as handed from the front end to the back end.
  typedef struct packed {
    logic [VAL_W-1:0]   start;
    logic [FIELD_W-1:0] step;
    logic [FIELD_W-1:0] last;
    logic               empty;
  } dtrs_job_t;

endpackage

`default_nettype wire

// ----- rtl/divisor_table_range_sum.sv -----
// Reset: rst_ni clears control state, then a clearing pass over all TABLE_SIZE entries and the
// sieve fill the tables (a prime test per candidate, a power table per prime, a read and a
// write per multiple of each prime); in_stall_o stays high until the fill is done.
// Flow: the front end runs a restoring divider to find the first multiple, then the back end
// makes one table read per multiple on the single read port; an empty range yields zero totals.
// The front end classifies the next query while the back end walks the current one.
`timescale 1ns / 1ps
`default_nettype none

module divisor_table_range_sum #(
  parameter int TABLE_SIZE = 65536
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire dtrs_pkg::dtrs_in_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output dtrs_pkg::dtrs_out_t       out_data_o
);

  import dtrs_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = (AW <= 16) ? 7 : 8;
  localparam int SW = AW + 3;
  localparam int WW = 1 + CW + SW;

  logic          fill_done;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;
  logic [AW-1:0] sieve_raddr;
  logic [AW-1:0] back_raddr;
  logic          job_valid;
  logic          job_pop;
  dtrs_job_t     job;

  // Table entry: composite mark, divisor count, divisor sum.
  dtrs_ram #(
    .WIDTH(WW),
    .DEPTH(TABLE_SIZE)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // The sieve owns the read port until the fill is complete.
  assign ram_raddr = fill_done ? back_raddr : sieve_raddr;

  dtrs_sieve #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_sieve (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(sieve_raddr),
    .ram_rdata_i(ram_rdata),
    .done_o     (fill_done)
  );

  dtrs_front #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ready_i    (fill_done),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .job_valid_o(job_valid),
    .job_o      (job),
    .job_pop_i  (job_pop)
  );

  dtrs_back #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job),
    .job_pop_o  (job_pop),
    .ram_raddr_o(back_raddr),
    .ram_rdata_i(ram_rdata),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ----- rtl/dtrs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/dtrs_sieve.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtrs_sieve #(
  parameter int TABLE_SIZE = 65536
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  output logic                                          ram_we_o,
  output logic [$clog2(TABLE_SIZE)-1:0]                 ram_waddr_o,
  output logic [$clog2(TABLE_SIZE)+(($clog2(TABLE_SIZE)<=16)?7:8)+3:0] ram_wdata_o,
  output logic [$clog2(TABLE_SIZE)-1:0]                 ram_raddr_o,
  input  wire logic [$clog2(TABLE_SIZE)+(($clog2(TABLE_SIZE)<=16)?7:8)+3:0] ram_rdata_i,
  output logic                                          done_o
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = (AW <= 16) ? 7 : 8;
  localparam int SW = AW + 3;
  localparam int WW = 1 + CW + SW;
  localparam int EW = $clog2(AW + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_TEST  = 3'd2;
  localparam logic [2:0] S_POW   = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [AW:0]   addr_q, addr_d;
  logic [AW-1:0] n_q, n_d;
  logic [EW-1:0] k_q, k_d;
  logic          first_q, first_d;
  logic [SW-1:0] pw_q, pw_d;
  logic [SW-1:0] run_q, run_d;
  logic [SW-1:0] ps_q [AW+1];
  logic [AW-1:0] dg_q [AW];
  logic [AW-1:0] dg_d [AW];
  logic          ps_we;
  logic          adv;
  logic          carry;
  logic [AW:0]   nxt;
  logic [EW-1:0] tz;
  logic [EW-1:0] expo;
  logic [EW:0]   expo_inc;
  logic [CW-1:0] rd_cnt;
  logic [SW-1:0] rd_sig;
  logic          rd_mark;

  assign rd_mark = ram_rdata_i[WW-1];
  assign rd_cnt  = ram_rdata_i[SW +: CW];
  assign rd_sig  = ram_rdata_i[0 +: SW];

  // Sieve sequencer: clearing pass, prime test, power table, then one
  // read-modify-write of every multiple of the prime.
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    n_d         = n_q;
    k_d         = k_q;
    pw_d        = pw_q;
    run_d       = run_q;
    dg_d        = dg_q;
    first_d     = first_q;
    ps_we       = 1'b0;
    adv         = 1'b0;
    carry       = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = addr_q[AW-1:0];
    ram_wdata_o = '0;
    ram_raddr_o = n_q;
    nxt         = addr_q + {1'b0, n_q};

    // The exponent of the prime in a multiple is one more than the number
    // of trailing zero digits of the cofactor written in base prime.
    tz = '0;
    for (int k = AW - 1; k >= 0; k--) begin
      if (dg_q[k] != '0) begin
        tz = EW'(k);
      end
    end
    expo     = tz + EW'(1);
    expo_inc = (EW+1)'(expo) + (EW+1)'(1);

    unique case (state_q)
      S_CLEAR: begin
        ram_we_o = 1'b1;
        if (addr_q != '0) begin
          ram_wdata_o = {1'b0, CW'(1), SW'(1)};
        end
        addr_d = addr_q + 1'b1;
        if (addr_q[AW-1:0] == AW'(TABLE_SIZE - 1)) begin
          n_d     = AW'(2);
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_TEST;
      end
      S_TEST: begin
        if (rd_mark) begin
          adv = 1'b1;
        end else begin
          pw_d    = SW'(n_q);
          run_d   = SW'(1);
          k_d     = EW'(1);
          state_d = S_POW;
        end
      end
      S_POW: begin
        run_d = run_q + pw_q;
        ps_we = 1'b1;
        pw_d  = SW'(pw_q * n_q);
        k_d   = k_q + 1'b1;
        if (k_q == EW'(AW)) begin
          addr_d = {1'b0, n_q};
          for (int k = 0; k < AW; k++) begin
            dg_d[k] = '0;
          end
          dg_d[0] = AW'(1);
          first_d = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        ram_raddr_o = addr_q[AW-1:0];
        state_d     = S_WR;
      end
      S_WR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = {rd_mark | ~first_q,
                       CW'(rd_cnt * expo_inc),
                       SW'(rd_sig * ps_q[expo])};
        first_d     = 1'b0;
        // Count the cofactor up by one in base prime.
        carry = 1'b1;
        for (int k = 0; k < AW; k++) begin
          if (carry) begin
            if (dg_q[k] == n_q - 1'b1) begin
              dg_d[k] = '0;
            end else begin
              dg_d[k] = dg_q[k] + 1'b1;
              carry   = 1'b0;
            end
          end
        end
        if (nxt > (AW+1)'(TABLE_SIZE - 1)) begin
          adv = 1'b1;
        end else begin
          addr_d  = nxt;
          state_d = S_RD;
        end
      end
      S_DONE: begin
        state_d = S_DONE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase

    // Move on to the next candidate, or finish after the last entry.
    if (adv) begin
      if (n_q == AW'(TABLE_SIZE - 1)) begin
        state_d = S_DONE;
      end else begin
        n_d     = n_q + 1'b1;
        state_d = S_CHECK;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      addr_q  <= '0;
      n_q     <= '0;
      k_q     <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      n_q     <= n_d;
      k_q     <= k_d;
      first_q <= first_d;
    end
  end

  // Power sums and digit counter of the current prime.
  always_ff @(posedge clk_i) begin
    pw_q  <= pw_d;
    run_q <= run_d;
    dg_q  <= dg_d;
    if (ps_we) begin
      ps_q[k_q] <= run_d;
    end
    if (state_q == S_TEST) begin
      ps_q[0] <= SW'(1);
    end
  end

  assign done_o = (state_q == S_DONE);

endmodule

`default_nettype wire

// ----- rtl/dtrs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtrs_front #(
  parameter int TABLE_SIZE = 65536
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 ready_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire dtrs_pkg::dtrs_in_t   in_data_i,
  output logic                      job_valid_o,
  output dtrs_pkg::dtrs_job_t       job_o,
  input  wire logic                 job_pop_i
);

  import dtrs_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_MUL  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;
  localparam int         CNT_W  = $clog2(VAL_W);

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [FIELD_W-1:0] first_q, first_d;
  logic [FIELD_W-1:0] last_q, last_d;
  logic [FIELD_W-1:0] step_q, step_d;
  logic [VAL_W-1:0]   div_q, div_d;
  logic [FIELD_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0]   quo_q, quo_d;
  logic [VAL_W-1:0]   start_q, start_d;
  logic [VAL_W-1:0]   trial;
  logic [VAL_W-1:0]   prod;
  logic               accept;
  logic               push;
  dtrs_job_t          job_new;

  dtrs_job_t fifo_q [2];
  logic      wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  assign in_stall_o = ~(ready_i && (state_q == F_IDLE));
  assign accept     = in_valid_i && !in_stall_o;
  assign trial      = {rem_q, div_q[VAL_W-1]};
  assign prod       = VAL_W'(quo_q * step_q);

  // Classify the query: clamp the range and find the first multiple.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    first_d = first_q;
    last_d  = last_q;
    step_d  = step_q;
    div_d   = div_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    start_d = start_q;
    push    = 1'b0;

    job_new.start = start_q;
    job_new.step  = step_q;
    job_new.last  = last_q;
    job_new.empty = (step_q == '0) || (first_q > last_q) ||
                    (start_q > {1'b0, last_q});

    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          first_d = in_data_i.range_first;
          step_d  = in_data_i.step_divisor;
          if (32'(in_data_i.range_last) > 32'(TABLE_SIZE - 1)) begin
            last_d = FIELD_W'(TABLE_SIZE - 1);
          end else begin
            last_d = in_data_i.range_last;
          end
          div_d   = {1'b0, in_data_i.range_first} + {1'b0, in_data_i.step_divisor}
                    - VAL_W'(1);
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (trial >= {1'b0, step_q}) begin
          rem_d = FIELD_W'(trial - {1'b0, step_q});
          quo_d = {quo_q[VAL_W-2:0], 1'b1};
        end else begin
          rem_d = trial[FIELD_W-1:0];
          quo_d = {quo_q[VAL_W-2:0], 1'b0};
        end
        div_d = {div_q[VAL_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(VAL_W - 1)) begin
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        // A range that starts at zero begins at the step itself.
        if (prod == '0) begin
          start_d = {1'b0, step_q};
        end else begin
          start_d = prod;
        end
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (fill_q != 2'd2) begin
          push    = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (job_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, job_pop_i})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

  // Query fields, divider state and the two-entry job queue.
  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    last_q  <= last_d;
    step_q  <= step_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    start_q <= start_d;
    if (push) begin
      fifo_q[wr_ptr_q] <= job_new;
    end
  end

  assign job_valid_o = (fill_q != '0);
  assign job_o       = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

// ----- rtl/dtrs_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtrs_back #(
  parameter int TABLE_SIZE = 65536
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     job_valid_i,
  input  wire dtrs_pkg::dtrs_job_t                      job_i,
  output logic                                          job_pop_o,
  output logic [$clog2(TABLE_SIZE)-1:0]                 ram_raddr_o,
  input  wire logic [$clog2(TABLE_SIZE)+(($clog2(TABLE_SIZE)<=16)?7:8)+3:0] ram_rdata_i,
  output logic                                          out_valid_o,
  input  wire logic                                     out_stall_i,
  output dtrs_pkg::dtrs_out_t                           out_data_o
);

  import dtrs_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = (AW <= 16) ? 7 : 8;
  localparam int SW = AW + 3;

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_RUN   = 2'd1;
  localparam logic [1:0] B_DRAIN = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [VAL_W-1:0]   idx_q, idx_d;
  logic [FIELD_W-1:0] step_q, step_d;
  logic [FIELD_W-1:0] last_q, last_d;
  logic               rd_vld_q, rd_vld_d;
  logic               out_vld_q, out_vld_d;
  logic [COUNT_W-1:0] acc_c_q, acc_c_d;
  logic [SIGMA_W-1:0] acc_s_q, acc_s_d;
  logic [COUNT_W-1:0] acc_c_nx;
  logic [SIGMA_W-1:0] acc_s_nx;
  logic [COUNT_W:0]   sum_c;
  logic [SIGMA_W:0]   sum_s;
  logic [VAL_W-1:0]   nxt;
  dtrs_out_t          out_q, out_d;

  // Saturating accumulation of the entry read in the previous cycle.
  always_comb begin
    sum_c = {1'b0, acc_c_q} + (COUNT_W+1)'(ram_rdata_i[SW +: CW]);
    sum_s = {1'b0, acc_s_q} + (SIGMA_W+1)'(ram_rdata_i[0 +: SW]);
    if (!rd_vld_q) begin
      acc_c_nx = acc_c_q;
      acc_s_nx = acc_s_q;
    end else begin
      acc_c_nx = sum_c[COUNT_W] ? '1 : sum_c[COUNT_W-1:0];
      acc_s_nx = sum_s[SIGMA_W] ? '1 : sum_s[SIGMA_W-1:0];
    end
  end

  // Walk the multiples, one table read per cycle.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    step_d      = step_q;
    last_d      = last_q;
    rd_vld_d    = 1'b0;
    acc_c_d     = acc_c_nx;
    acc_s_d     = acc_s_nx;
    out_d       = out_q;
    out_vld_d   = out_vld_q && out_stall_i;
    job_pop_o   = 1'b0;
    ram_raddr_o = AW'(idx_q);
    nxt         = idx_q + {1'b0, step_q};

    unique case (state_q)
      B_IDLE: begin
        if (job_valid_i && !out_vld_q) begin
          job_pop_o = 1'b1;
          if (job_i.empty) begin
            out_d     = '0;
            out_vld_d = 1'b1;
          end else begin
            idx_d   = job_i.start;
            step_d  = job_i.step;
            last_d  = job_i.last;
            acc_c_d = '0;
            acc_s_d = '0;
            state_d = B_RUN;
          end
        end
      end
      B_RUN: begin
        rd_vld_d = 1'b1;
        if (nxt > {1'b0, last_q}) begin
          state_d = B_DRAIN;
        end else begin
          idx_d = nxt;
        end
      end
      B_DRAIN: begin
        out_d.count_total = acc_c_nx;
        out_d.sigma_total = acc_s_nx;
        out_vld_d         = 1'b1;
        state_d           = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Walk position, accumulators and the result register.
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    step_q  <= step_d;
    last_q  <= last_d;
    acc_c_q <= acc_c_d;
    acc_s_q <= acc_s_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/dtrs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtrs_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire dtrs_pkg::dtrs_out_t out_data_o
);

  import dtrs_pkg::*;

  // A result transaction that is stalled stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // The tables are being filled right after reset, so no query is taken.
  a_fill_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("query taken before the table fill");

  // Every selected entry has a nonzero count and sum, so both totals are zero together.
  a_zero_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.count_total == '0) == (out_data_o.sigma_total == '0)))
    else $error("count and sum totals disagree on emptiness");

  // The divisor count never exceeds the divisor sum.
  a_count_le_sigma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (SIGMA_W'(out_data_o.count_total) <= out_data_o.sigma_total))
    else $error("count total exceeds sum total");

endmodule

bind divisor_table_range_sum dtrs_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

`default_nettype wire
